@@ rtl/assert_macros.svh @@
// Assertion macros used by the checker file of the hashing block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low
`define SHA_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while rst_ni is low
`define SHA_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/sha_pkg.sv @@
// Shared types, constants and round functions of the SHA-256 hashing block.
package sha_pkg;

  localparam int unsigned QueueDepthDef = 16;
  localparam int unsigned Rounds        = 64;
  localparam int unsigned SchedWords    = 16;
  localparam int unsigned DigestWords   = 8;
  localparam int unsigned BlockBytes    = 64;
  localparam int unsigned LenHiWord     = 14;
  localparam logic [7:0]  PadByte       = 8'h80;

  // One 32-bit message word on its way from the front end to the core
  typedef struct packed {
    logic [31:0] data;
    logic        last;
  } sha_word_t;

  // Word push request from the front end into the queue
  typedef struct packed {
    logic      valid;
    sha_word_t word;
  } sha_push_t;

  localparam logic [31:0] InitHash [DigestWords] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] RoundK [Rounds] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  // Upper-case sigma 0: rotate right by 2, 13 and 22
  function automatic logic [31:0] big_sig0(input logic [31:0] x);
    return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  // Upper-case sigma 1: rotate right by 6, 11 and 25
  function automatic logic [31:0] big_sig1(input logic [31:0] x);
    return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  // Lower-case sigma 0: rotate right by 7 and 18, shift right by 3
  function automatic logic [31:0] small_sig0(input logic [31:0] x);
    return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  // Lower-case sigma 1: rotate right by 17 and 19, shift right by 10
  function automatic logic [31:0] small_sig1(input logic [31:0] x);
    return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
  endfunction

endpackage

@@ rtl/sha_if.sv @@
// Valid/ready channel interfaces for message bytes and digest words.
interface sha_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       has_byte;
  logic       end_of_message;

  modport source (output valid, data_byte, has_byte, end_of_message, input ready);
  modport sink   (input valid, data_byte, has_byte, end_of_message, output ready);
endinterface

interface sha_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;

  modport source (output valid, digest_word, word_index, last_word, input ready);
  modport sink   (input valid, digest_word, word_index, last_word, output ready);
endinterface

@@ rtl/sha_front.sv @@
// Front end: packs message bytes into words, tracks length, generates padding.
module sha_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  sha_in_if.sink             msg_i,
  input  logic               full_i,
  output sha_pkg::sha_push_t push_o
);
  import sha_pkg::*;

  typedef enum logic [2:0] {
    P_IDLE,
    P_FIRST,
    P_ZERO,
    P_LENHI,
    P_LENLO
  } pad_state_e;

  pad_state_e  pst_q, pst_d;
  logic [3:0]  wi_q, wi_d;
  logic [5:0]  cnt_q, cnt_d;
  logic [54:0] blocks_q, blocks_d;
  logic [23:0] acc_q, acc_d;
  logic [63:0] total_bits;
  logic [31:0] first_word;
  logic        accept;

  // Message length in bits: whole blocks, bytes held, times eight
  assign total_bits = {blocks_q, cnt_q, 3'b000};

  // Take bytes only while no padding is pending and the queue has room
  assign msg_i.ready = (pst_q == P_IDLE) && !full_i;
  assign accept      = msg_i.valid && msg_i.ready;

  // Close the partial word with the pad marker
  always_comb begin
    case (cnt_q[1:0])
      2'd0:    first_word = {PadByte, 24'h0};
      2'd1:    first_word = {acc_q[7:0], PadByte, 16'h0};
      2'd2:    first_word = {acc_q[15:0], PadByte, 8'h0};
      default: first_word = {acc_q[23:0], PadByte};
    endcase
  end

  // Absorb bytes, then walk the padding words into the queue
  always_comb begin
    pst_d    = pst_q;
    wi_d     = wi_q;
    cnt_d    = cnt_q;
    blocks_d = blocks_q;
    acc_d    = acc_q;
    push_o   = '0;
    case (pst_q)
      P_IDLE: begin
        if (accept) begin
          if (msg_i.has_byte) begin
            acc_d = {acc_q[15:0], msg_i.data_byte};
            cnt_d = cnt_q + 6'd1;
            if (cnt_q == 6'(BlockBytes - 1)) begin
              blocks_d = blocks_q + 55'd1;
            end
            if (cnt_q[1:0] == 2'd3) begin
              push_o.valid      = 1'b1;
              push_o.word.data  = {acc_q, msg_i.data_byte};
              push_o.word.last  = 1'b0;
            end
          end
          if (msg_i.end_of_message) begin
            pst_d = P_FIRST;
          end
        end
      end
      P_FIRST: begin
        if (!full_i) begin
          push_o.valid     = 1'b1;
          push_o.word.data = first_word;
          if (cnt_q[5:2] == 4'(LenHiWord - 1)) begin
            pst_d = P_LENHI;
          end else begin
            // Zero-fill up to the length, in one more block if it does not fit
            pst_d = P_ZERO;
            wi_d  = cnt_q[5:2] + 4'd1;
          end
        end
      end
      P_ZERO: begin
        if (!full_i) begin
          push_o.valid = 1'b1;
          if (wi_q == 4'(LenHiWord - 1)) begin
            pst_d = P_LENHI;
          end else begin
            wi_d = wi_q + 4'd1;
          end
        end
      end
      P_LENHI: begin
        if (!full_i) begin
          push_o.valid     = 1'b1;
          push_o.word.data = total_bits[63:32];
          pst_d            = P_LENLO;
        end
      end
      P_LENLO: begin
        if (!full_i) begin
          push_o.valid     = 1'b1;
          push_o.word.data = total_bits[31:0];
          push_o.word.last = 1'b1;
          cnt_d            = '0;
          blocks_d         = '0;
          pst_d            = P_IDLE;
        end
      end
      default: pst_d = P_IDLE;
    endcase
  end

  // Hold pad state, byte count, block count and partial word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pst_q    <= P_IDLE;
      wi_q     <= '0;
      cnt_q    <= '0;
      blocks_q <= '0;
      acc_q    <= '0;
    end else begin
      pst_q    <= pst_d;
      wi_q     <= wi_d;
      cnt_q    <= cnt_d;
      blocks_q <= blocks_d;
      acc_q    <= acc_d;
    end
  end

endmodule

@@ rtl/sha_fifo.sv @@
// Word queue that decouples the front end from the compression core.
module sha_fifo #(
  parameter int unsigned Depth = sha_pkg::QueueDepthDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  sha_pkg::sha_push_t push_i,
  output logic               full_o,
  input  logic               pop_i,
  output sha_pkg::sha_word_t head_o,
  output logic               valid_o
);
  import sha_pkg::*;

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);

  sha_word_t       mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign valid_o = (cnt_q != '0);
  assign head_o  = mem_q[rd_ptr_q];
  assign do_push = push_i.valid && !full_o;
  assign do_pop  = pop_i && valid_o;

  // Advance pointers and occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (!do_push && do_pop) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

  // Store pushed words
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_i.word;
    end
  end

endmodule

@@ rtl/sha_core.sv @@
// Compression core: one SHA-256 round per cycle unless stalled on the queue, hash update, digest output.
module sha_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  sha_pkg::sha_word_t head_i,
  input  logic               head_valid_i,
  output logic               pop_o,
  sha_out_if.source          dig_o
);
  import sha_pkg::*;

  typedef enum logic [1:0] {
    C_ROUND,
    C_FINAL,
    C_DIGEST
  } core_state_e;

  core_state_e state_q, state_d;
  logic [5:0]  r_q, r_d;
  logic [2:0]  idx_q, idx_d;
  logic        last_q, last_d;
  logic [31:0] h_q [DigestWords];
  logic [31:0] h_d [DigestWords];
  logic [31:0] v_q [DigestWords];
  logic [31:0] v_d [DigestWords];
  logic [31:0] w_q [SchedWords];
  logic [31:0] w_d [SchedWords];
  logic        out_valid_q, out_valid_d;
  logic [31:0] out_word_q, out_word_d;
  logic [2:0]  out_idx_q, out_idx_d;
  logic        out_last_q, out_last_d;
  logic        sched_early;
  logic [31:0] wt, sched_new, t1, t2, ch, maj;

  // Round word: from the queue for the first sixteen rounds, then expanded
  assign sched_early = (r_q < 6'(SchedWords));
  assign sched_new   = small_sig1(w_q[SchedWords-2]) + w_q[SchedWords-7]
                     + small_sig0(w_q[1]) + w_q[0];
  assign wt          = sched_early ? head_i.data : sched_new;

  // Round function
  assign ch  = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
  assign maj = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
  assign t1  = v_q[7] + big_sig1(v_q[4]) + ch + RoundK[r_q] + wt;
  assign t2  = big_sig0(v_q[0]) + maj;

  assign dig_o.valid       = out_valid_q;
  assign dig_o.digest_word = out_word_q;
  assign dig_o.word_index  = out_idx_q;
  assign dig_o.last_word   = out_last_q;

  always_comb begin
    state_d     = state_q;
    r_d         = r_q;
    idx_d       = idx_q;
    last_d      = last_q;
    h_d         = h_q;
    v_d         = v_q;
    w_d         = w_q;
    pop_o       = 1'b0;
    out_valid_d = out_valid_q && !dig_o.ready;
    out_word_d  = out_word_q;
    out_idx_d   = out_idx_q;
    out_last_d  = out_last_q;
    case (state_q)
      C_ROUND: begin
        // Stall early rounds until the next message word is queued
        if (!sched_early || head_valid_i) begin
          pop_o = sched_early;
          v_d[7] = v_q[6];
          v_d[6] = v_q[5];
          v_d[5] = v_q[4];
          v_d[4] = v_q[3] + t1;
          v_d[3] = v_q[2];
          v_d[2] = v_q[1];
          v_d[1] = v_q[0];
          v_d[0] = t1 + t2;
          for (int i = 0; i < SchedWords - 1; i++) begin
            w_d[i] = w_q[i+1];
          end
          w_d[SchedWords-1] = wt;
          if (r_q == 6'(SchedWords - 1)) begin
            last_d = head_i.last;
          end
          r_d = r_q + 6'd1;
          if (r_q == 6'(Rounds - 1)) begin
            state_d = C_FINAL;
          end
        end
      end
      C_FINAL: begin
        // Fold the working variables into the hash
        for (int i = 0; i < DigestWords; i++) begin
          h_d[i] = h_q[i] + v_q[i];
          v_d[i] = h_q[i] + v_q[i];
        end
        idx_d   = '0;
        state_d = last_q ? C_DIGEST : C_ROUND;
      end
      C_DIGEST: begin
        // Hand out one digest word whenever the output register frees up
        if (!out_valid_q || dig_o.ready) begin
          out_valid_d = 1'b1;
          out_word_d  = h_q[idx_q];
          out_idx_d   = idx_q;
          out_last_d  = (idx_q == 3'(DigestWords - 1));
          idx_d       = idx_q + 3'd1;
          if (idx_q == 3'(DigestWords - 1)) begin
            h_d     = InitHash;
            v_d     = InitHash;
            state_d = C_ROUND;
          end
        end
      end
      default: state_d = C_ROUND;
    endcase
  end

  // Hold state, hash, working variables and the output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= C_ROUND;
      r_q         <= '0;
      idx_q       <= '0;
      last_q      <= 1'b0;
      h_q         <= InitHash;
      v_q         <= InitHash;
      out_valid_q <= 1'b0;
      out_word_q  <= '0;
      out_idx_q   <= '0;
      out_last_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      r_q         <= r_d;
      idx_q       <= idx_d;
      last_q      <= last_d;
      h_q         <= h_d;
      v_q         <= v_d;
      out_valid_q <= out_valid_d;
      out_word_q  <= out_word_d;
      out_idx_q   <= out_idx_d;
      out_last_q  <= out_last_d;
    end
  end

  // Shift the message schedule window
  always_ff @(posedge clk_i) begin
    w_q <= w_d;
  end

endmodule

@@ rtl/sha256_stream_hasher.sv @@
// Throughput: one message byte per cycle while no padding is pending and the word queue
// has room; one round unit does each 64-byte block in 64 rounds and one hash update.
// The front end queues 3 to 18 padding words after the end item, one per cycle while the
// queue has room; the digest follows as eight words, back to back while dig_o is ready.
// Reset: clears hash to its initial values, counters, queue and output register at once;
// no clearing pass, the block takes items right after reset.
module sha256_stream_hasher #(
  parameter int unsigned QueueDepth = sha_pkg::QueueDepthDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  sha_in_if.sink     msg_i,
  sha_out_if.source  dig_o
);
  import sha_pkg::*;

  sha_push_t push;
  sha_word_t head;
  logic      full, head_valid, pop;

  sha_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .msg_i  (msg_i),
    .full_i (full),
    .push_o (push)
  );

  sha_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .full_o  (full),
    .pop_i   (pop),
    .head_o  (head),
    .valid_o (head_valid)
  );

  sha_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_i       (head),
    .head_valid_i (head_valid),
    .pop_o        (pop),
    .dig_o        (dig_o)
  );

endmodule

@@ rtl/sha_checker.sv @@
// Port-level checks of the hashing block, bound to its top level.
`include "assert_macros.svh"

module sha_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        msg_valid_i,
  input logic        msg_ready_i,
  input logic        msg_eom_i,
  input logic        dig_valid_i,
  input logic        dig_ready_i,
  input logic [31:0] dig_word_i,
  input logic [2:0]  dig_index_i,
  input logic        dig_last_i
);
  localparam logic [2:0] LastIdx = 3'd7;

  // Stalled digest transaction keeps its payload
  `SHA_ASSERT_NXT(a_dig_hold, dig_valid_i && !dig_ready_i,
                  dig_valid_i && $stable(dig_word_i) && $stable(dig_index_i),
                  "digest word changed while stalled")

  // Last flag marks exactly the final digest word
  `SHA_ASSERT_IMP(a_last_idx, dig_valid_i, dig_last_i == (dig_index_i == LastIdx),
                  "last_word does not match word_index")

  // Padding blocks new bytes right after an end transaction
  `SHA_ASSERT_NXT(a_pad_stall, msg_valid_i && msg_ready_i && msg_eom_i, !msg_ready_i,
                  "input accepted while padding")

  // Digest words come out in order, with no word index skipped
  `SHA_ASSERT_NXT(a_idx_seq, dig_valid_i && dig_ready_i && !dig_last_i,
                  !dig_valid_i || (dig_index_i == 3'($past(dig_index_i) + 3'd1)),
                  "digest word index out of sequence")

endmodule

bind sha256_stream_hasher sha_checker u_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .msg_valid_i (msg_i.valid),
  .msg_ready_i (msg_i.ready),
  .msg_eom_i   (msg_i.end_of_message),
  .dig_valid_i (dig_o.valid),
  .dig_ready_i (dig_o.ready),
  .dig_word_i  (dig_o.digest_word),
  .dig_index_i (dig_o.word_index),
  .dig_last_i  (dig_o.last_word)
);
